>>> rtl/srf_pkg.sv
package srf_pkg;

  localparam int STORE_DEPTH_DEFAULT     = 65536;
  localparam int MAX_SIDE_DEFAULT        = 256;
  localparam int MAX_CHANNELS_DEFAULT    = 4;
  localparam int ANGLE_FRAC_BITS_DEFAULT = 14;

  localparam int SAMPLE_W   = 8;
  localparam int ADDR_W     = 16;
  localparam int CMD_W      = 2;
  localparam int SIZE_W     = 9;
  localparam int CHAN_CFG_W = 3;
  localparam int ANGLE_W    = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLICE_COUNT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COS_ANGLE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN_ANGLE     = 3'd5;

  localparam logic [SIZE_W-1:0]     RST_IMAGE_WIDTH   = 9'd256;
  localparam logic [SIZE_W-1:0]     RST_IMAGE_HEIGHT  = 9'd256;
  localparam logic [SIZE_W-1:0]     RST_SLICE_COUNT   = 9'd1;
  localparam logic [CHAN_CFG_W-1:0] RST_CHANNEL_COUNT = 3'd1;
  localparam logic [ANGLE_W-1:0]    RST_COS_ANGLE     = 16'sd16384;
  localparam logic [ANGLE_W-1:0]    RST_SIN_ANGLE     = 16'sd0;

  localparam logic [SAMPLE_W-1:0] FILL_VALUE = 8'hFF;

endpackage

>>> rtl/srf_ifs.sv
interface srf_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [srf_pkg::CMD_W-1:0]    command;
  logic [srf_pkg::SAMPLE_W-1:0] sample_in;
  logic [srf_pkg::ADDR_W-1:0]   read_address;

  modport source(output valid, command, sample_in, read_address, input ready);
  modport sink(input valid, command, sample_in, read_address, output ready);
endinterface

interface srf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [srf_pkg::SAMPLE_W-1:0] sample_out;

  modport source(output valid, sample_out, input ready);
  modport sink(input valid, sample_out, output ready);
endinterface

>>> rtl/slice_rotate_forward_scatter.sv
// Rotates every z-slice of a volume about its center by forward mapping into an 8-bit
// output store of STORE_DEPTH words (nearest neighbor, later pixels win). Commands: clear
// (fill the store with 255 and restart the raster walk), write (next sample, channel
// fastest, then column, row, slice), read (one word returned on rsp; reads beyond the
// store return 0), and no-op. Sequence: the first channel of a pixel goes through center
// offset, four parallel multiplies, sum, truncate and range check, three index multiply
// steps and the store write; each further channel of that pixel is written as it is accepted;
// a read passes the store read register, then the output register, and may wait on rsp; a clear
// fills the store through the single store write port, one word per cycle. After reset the
// same fill runs with cmd.ready low; configuration writes are taken at any time but must only
// be issued while the block is idle.
module slice_rotate_forward_scatter #(
  parameter int STORE_DEPTH     = srf_pkg::STORE_DEPTH_DEFAULT,
  parameter int MAX_SIDE        = srf_pkg::MAX_SIDE_DEFAULT,
  parameter int MAX_CHANNELS    = srf_pkg::MAX_CHANNELS_DEFAULT,
  parameter int ANGLE_FRAC_BITS = srf_pkg::ANGLE_FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [srf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [srf_pkg::CFG_DATA_W-1:0]     cfg_data,
  srf_cmd_if.sink                            cmd,
  srf_rsp_if.source                          rsp
);

  localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int RAW    = (AW > srf_pkg::ADDR_W) ? AW : srf_pkg::ADDR_W;
  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int EFF_W  = $clog2(MAX_SIDE + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CE_W   = $clog2(MAX_CHANNELS + 1);
  localparam int XY_W   = EFF_W + 2;
  localparam int PW     = XY_W + srf_pkg::ANGLE_W;
  localparam int CW     = EFF_W + ANGLE_FRAC_BITS + 1;
  localparam int NW_W   = ((PW > CW) ? PW : CW) + 2;
  localparam int SH     = ANGLE_FRAC_BITS + 1;
  localparam int T1_W   = $clog2(longint'(MAX_SIDE) * MAX_SIDE);
  localparam int T2_W   = $clog2(longint'(MAX_SIDE) * MAX_SIDE * MAX_SIDE);
  localparam int BASE_W = $clog2(longint'(MAX_SIDE) * MAX_SIDE * MAX_SIDE * MAX_CHANNELS);
  localparam int IW     = (BASE_W > AW) ? BASE_W : AW;

  localparam logic [AW-1:0]          LAST_ADDR = AW'(STORE_DEPTH - 1);
  localparam logic signed [NW_W-1:0] RND       = NW_W'((longint'(1) << SH) - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_DEST  = 4'd4;
  localparam logic [3:0] ST_IDX1  = 4'd5;
  localparam logic [3:0] ST_IDX2  = 4'd6;
  localparam logic [3:0] ST_IDX3  = 4'd7;
  localparam logic [3:0] ST_WRITE = 4'd8;
  localparam logic [3:0] ST_READ  = 4'd9;

  logic [3:0] state, state_next;

  logic [srf_pkg::SIZE_W-1:0]        image_width, image_height, slice_count;
  logic [srf_pkg::CHAN_CFG_W-1:0]    channel_count;
  logic signed [srf_pkg::ANGLE_W-1:0] cos_angle, sin_angle;

  logic [EFF_W-1:0] w_eff, h_eff, d_eff;
  logic [CE_W-1:0]  c_eff;

  logic [SIDE_W-1:0] column_position, row_position, slice_position;
  logic [SIDE_W-1:0] column_position_next, row_position_next, slice_position_next;
  logic [CH_W-1:0]   channel_position, channel_position_next;

  logic                     target_valid;
  logic [BASE_W-1:0]        target_base;
  logic [srf_pkg::SAMPLE_W-1:0] sample;

  logic signed [XY_W-1:0] x, y, x_next, y_next;
  logic signed [PW-1:0]   p_xc, p_ys, p_yc, p_xs;
  logic signed [NW_W-1:0] nw, nh, nw_adj, nh_adj, wt, ht;
  logic [SIDE_W-1:0]      dw, dh;
  logic [T1_W-1:0]        t1;
  logic [T2_W-1:0]        t2;
  logic                   w_ok, h_ok;

  logic [AW-1:0] clr_addr;

  logic                         accept;
  logic                         do_write;
  logic [IW-1:0]                idx;
  logic                         idx_ok;
  logic [srf_pkg::SAMPLE_W-1:0] wr_sample;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [srf_pkg::SAMPLE_W-1:0] mem_wdata;
  logic                         rd_en;
  logic [RAW-1:0]               ra;
  logic                         rd_ok, rd_ok_next;
  logic [srf_pkg::SAMPLE_W-1:0] rd_data;

  logic                         out_valid;
  logic [srf_pkg::SAMPLE_W-1:0] out_sample;
  logic                         out_free;

  logic [srf_pkg::SAMPLE_W-1:0] store [STORE_DEPTH];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= srf_pkg::RST_IMAGE_WIDTH;
      image_height  <= srf_pkg::RST_IMAGE_HEIGHT;
      slice_count   <= srf_pkg::RST_SLICE_COUNT;
      channel_count <= srf_pkg::RST_CHANNEL_COUNT;
      cos_angle     <= srf_pkg::RST_COS_ANGLE;
      sin_angle     <= srf_pkg::RST_SIN_ANGLE;
    end else if (cfg_we) begin
      case (cfg_index)
        srf_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[srf_pkg::SIZE_W-1:0];
        srf_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[srf_pkg::SIZE_W-1:0];
        srf_pkg::REG_SLICE_COUNT:   slice_count   <= cfg_data[srf_pkg::SIZE_W-1:0];
        srf_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[srf_pkg::CHAN_CFG_W-1:0];
        srf_pkg::REG_COS_ANGLE:     cos_angle     <= cfg_data;
        srf_pkg::REG_SIN_ANGLE:     sin_angle     <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    w_eff = (image_width == '0) ? EFF_W'(1) :
            (32'(image_width) > MAX_SIDE) ? EFF_W'(MAX_SIDE) : EFF_W'(image_width);
    h_eff = (image_height == '0) ? EFF_W'(1) :
            (32'(image_height) > MAX_SIDE) ? EFF_W'(MAX_SIDE) : EFF_W'(image_height);
    d_eff = (slice_count == '0) ? EFF_W'(1) :
            (32'(slice_count) > MAX_SIDE) ? EFF_W'(MAX_SIDE) : EFF_W'(slice_count);
    c_eff = (channel_count == '0) ? CE_W'(1) :
            (32'(channel_count) > MAX_CHANNELS) ? CE_W'(MAX_CHANNELS) : CE_W'(channel_count);
  end

  assign accept   = cmd.valid && (state == ST_IDLE);
  assign cmd.ready = (state == ST_IDLE);
  assign out_free = !out_valid || rsp.ready;

  // doubled center offsets
  assign x_next = $signed(XY_W'({column_position, 1'b0})) - $signed(XY_W'(w_eff - EFF_W'(1)));
  assign y_next = $signed(XY_W'({row_position, 1'b0})) - $signed(XY_W'(h_eff - EFF_W'(1)));

  // truncation toward zero
  always_comb begin
    nw_adj = nw + (nw[NW_W-1] ? RND : '0);
    nh_adj = nh + (nh[NW_W-1] ? RND : '0);
    wt     = nw_adj >>> SH;
    ht     = nh_adj >>> SH;
    w_ok   = !wt[NW_W-1] && (wt < $signed(NW_W'(w_eff)));
    h_ok   = !ht[NW_W-1] && (ht < $signed(NW_W'(h_eff)));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.command)
            srf_pkg::CMD_CLEAR: state_next = ST_CLEAR;
            srf_pkg::CMD_WRITE: state_next = (channel_position == '0) ? ST_MUL : ST_IDLE;
            srf_pkg::CMD_READ:  state_next = ST_READ;
            default:            state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_DEST;
      ST_DEST:  state_next = ST_IDX1;
      ST_IDX1:  state_next = ST_IDX2;
      ST_IDX2:  state_next = ST_IDX3;
      ST_IDX3:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_IDLE;
      ST_READ:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // raster advance
  always_comb begin
    channel_position_next = channel_position;
    column_position_next  = column_position;
    row_position_next     = row_position;
    slice_position_next   = slice_position;
    if (32'(channel_position) + 1 >= 32'(c_eff)) begin
      channel_position_next = '0;
      if (32'(column_position) + 1 >= 32'(w_eff)) begin
        column_position_next = '0;
        if (32'(row_position) + 1 >= 32'(h_eff)) begin
          row_position_next = '0;
          if (32'(slice_position) + 1 >= 32'(d_eff)) begin
            slice_position_next = '0;
          end else begin
            slice_position_next = slice_position + SIDE_W'(1);
          end
        end else begin
          row_position_next = row_position + SIDE_W'(1);
        end
      end else begin
        column_position_next = column_position + SIDE_W'(1);
      end
    end else begin
      channel_position_next = channel_position + CH_W'(1);
    end
  end

  // store port; reads and writes never share a cycle, the sequencer keeps them apart
  assign do_write  = (state == ST_WRITE) ||
                     (accept && (cmd.command == srf_pkg::CMD_WRITE) && (channel_position != '0));
  assign idx       = IW'(target_base) + IW'(channel_position);
  assign idx_ok    = 64'(idx) < 64'(STORE_DEPTH);
  assign wr_sample = (state == ST_WRITE) ? sample : cmd.sample_in;
  assign mem_we    = (state == ST_CLEAR) || (do_write && target_valid && idx_ok);
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : idx[AW-1:0];
  assign mem_wdata = (state == ST_CLEAR) ? srf_pkg::FILL_VALUE : wr_sample;
  assign rd_en     = accept && (cmd.command == srf_pkg::CMD_READ);
  assign ra        = RAW'(cmd.read_address);
  assign rd_ok_next = 64'(cmd.read_address) < 64'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data <= store[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      column_position  <= '0;
      row_position     <= '0;
      slice_position   <= '0;
      channel_position <= '0;
      target_valid     <= 1'b0;
      target_base      <= '0;
      rd_ok            <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (accept && (cmd.command == srf_pkg::CMD_CLEAR)) begin
        clr_addr         <= '0;
        column_position  <= '0;
        row_position     <= '0;
        slice_position   <= '0;
        channel_position <= '0;
        target_valid     <= 1'b0;
        target_base      <= '0;
      end
      if (do_write) begin
        column_position  <= column_position_next;
        row_position     <= row_position_next;
        slice_position   <= slice_position_next;
        channel_position <= channel_position_next;
      end
      if (state == ST_DEST) target_valid <= w_ok && h_ok;
      if (state == ST_IDX3) target_base <= BASE_W'(t2) * BASE_W'(c_eff);
      if (rd_en) rd_ok <= rd_ok_next;
    end
  end

  // destination datapath
  always_ff @(posedge clk) begin
    if (accept && (cmd.command == srf_pkg::CMD_WRITE)) begin
      sample <= cmd.sample_in;
      x      <= x_next;
      y      <= y_next;
    end
    if (state == ST_MUL) begin
      p_xc <= PW'(x) * PW'(cos_angle);
      p_ys <= PW'(y) * PW'(sin_angle);
      p_yc <= PW'(y) * PW'(cos_angle);
      p_xs <= PW'(x) * PW'(sin_angle);
    end
    if (state == ST_SUM) begin
      nw <= NW_W'(p_xc) + NW_W'(p_ys) +
            $signed(NW_W'({w_eff, {ANGLE_FRAC_BITS{1'b0}}}));
      nh <= NW_W'(p_yc) - NW_W'(p_xs) +
            $signed(NW_W'({h_eff, {ANGLE_FRAC_BITS{1'b0}}}));
    end
    if (state == ST_DEST) begin
      dw <= wt[SIDE_W-1:0];
      dh <= ht[SIDE_W-1:0];
    end
    if (state == ST_IDX1) t1 <= T1_W'(slice_position) * T1_W'(h_eff) + T1_W'(dh);
    if (state == ST_IDX2) t2 <= T2_W'(t1) * T2_W'(w_eff) + T2_W'(dw);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_READ) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_READ) && out_free) out_sample <= rd_ok ? rd_data : '0;
  end

  assign rsp.valid      = out_valid;
  assign rsp.sample_out = out_sample;

endmodule

>>> rtl/srf_checker.sv
module srf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic [srf_pkg::CMD_W-1:0]    cmd_command,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [srf_pkg::SAMPLE_W-1:0] rsp_sample_out
);

  // fill pass follows reset
  a_reset_fill: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("ready high right after reset");

  a_clear_fill: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_command == srf_pkg::CMD_CLEAR) |=> !cmd_ready)
    else $error("ready high right after clear");

  // a new word appears only in answer to an accepted read
  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |->
      $past(cmd_valid && cmd_ready && (cmd_command == srf_pkg::CMD_READ), 2))
    else $error("response without read");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
    else $error("stalled response dropped or changed");

endmodule

bind slice_rotate_forward_scatter srf_checker u_srf_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_command    (cmd.command),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_sample_out (rsp.sample_out)
);
